### sv/ipv4p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_pkg
// Shared types and character codes for the dotted IPv4 address parser.
// ----------------------------------------------------------------------------
package ipv4p_pkg;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_TRAIL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  typedef enum logic {
    OUT_PENDING = 1'b0,
    OUT_INVALID = 1'b1
  } outcome_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam logic [31:0] MAX_BYTE  = 32'h0000_00ff;
  localparam logic [31:0] MAX_SHORT = 32'h0000_ffff;
  localparam logic [31:0] MAX_24    = 32'h00ff_ffff;

  localparam logic [1:0] MAX_EARLIER = 2'd3;

  typedef struct packed {
    logic        ok;
    logic [31:0] value;
  } ipv4p_result_t;

endpackage

### sv/ipv4p_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_in_reg
// Input register: holds one character item until the parse stage takes it.
// ----------------------------------------------------------------------------
module ipv4p_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic       in_valid,
  input  logic [7:0] in_char_code,
  output logic       c_valid,
  output logic [7:0] c_char
);
  import ipv4p_pkg::*;

  logic       c_valid_r;
  logic       c_valid_nxt;
  logic [7:0] c_char_r;

  always_comb begin
    c_valid_nxt = c_valid_r;
    if (load) begin
      c_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= c_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      c_char_r <= in_char_code;
    end
  end

  assign c_valid = c_valid_r;
  assign c_char  = c_char_r;

endmodule

### sv/ipv4p_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_parse
// Parse state and per-character update; forms the address on the NUL item.
// ----------------------------------------------------------------------------
module ipv4p_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step_en,
  input  logic [7:0]               c_char,
  output ipv4p_pkg::ipv4p_result_t result
);
  import ipv4p_pkg::*;

  phase_t      phase_r, phase_nxt;
  base_t       base_r, base_nxt;
  logic [31:0] value_r, value_nxt;
  logic        ovf_r, ovf_nxt;
  logic [1:0]  parts_r, parts_nxt;
  outcome_t    outcome_r, outcome_nxt;
  logic [7:0]  earlier_r [3];

  logic        part_wr;
  logic        do_digit;
  base_t       base_e;
  logic        is_dec;
  logic        is_hex_alpha;
  logic        is_space;
  logic [3:0]  digit;
  logic [35:0] ext;
  logic [35:0] prod;
  logic [35:0] sum;
  logic        ok;
  logic [31:0] addr;

  // base in effect for this character
  always_comb begin
    case (phase_r)
      PH_START: base_e = (c_char == CH_ZERO) ? BASE_OCT : BASE_DEC;
      PH_ZERO:  base_e = (c_char == CH_LO_X || c_char == CH_UP_X) ? BASE_HEX : BASE_OCT;
      default:  base_e = base_r;
    endcase
  end

  assign is_dec       = (c_char inside {[CH_ZERO:CH_NINE]});
  assign is_hex_alpha = (base_e == BASE_HEX) &&
                        (c_char inside {[CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]});
  assign is_space     = (c_char inside {CH_SPACE, [CH_TAB:CH_CR]});
  // letters a-f and A-F have low nibble 1..6
  assign digit        = is_dec ? c_char[3:0] : c_char[3:0] + 4'd9;

  assign ext  = {4'b0, value_r};
  always_comb begin
    case (base_e)
      BASE_HEX: prod = ext << 4;
      BASE_OCT: prod = ext << 3;
      default:  prod = (ext << 3) + (ext << 1);
    endcase
  end
  assign sum = prod + {32'b0, digit};

  always_comb begin
    phase_nxt   = phase_r;
    base_nxt    = base_r;
    value_nxt   = value_r;
    ovf_nxt     = ovf_r;
    parts_nxt   = parts_r;
    outcome_nxt = outcome_r;
    part_wr     = 1'b0;
    do_digit    = 1'b0;
    if (step_en) begin
      if (c_char == CH_NUL) begin
        phase_nxt   = PH_START;
        base_nxt    = BASE_DEC;
        value_nxt   = '0;
        ovf_nxt     = 1'b0;
        parts_nxt   = '0;
        outcome_nxt = OUT_PENDING;
      end else if (outcome_r == OUT_PENDING && phase_r != PH_TRAIL) begin
        case (phase_r)
          PH_START: begin
            if (c_char == CH_ZERO) begin
              phase_nxt = PH_ZERO;
            end else begin
              phase_nxt = PH_DIGITS;
              do_digit  = 1'b1;
            end
          end
          PH_ZERO: begin
            phase_nxt = PH_DIGITS;
            if (!(c_char == CH_LO_X || c_char == CH_UP_X)) begin
              do_digit = 1'b1;
            end
          end
          default: begin
            do_digit = 1'b1;
          end
        endcase
        base_nxt = base_e;
        if (do_digit) begin
          if (is_dec || is_hex_alpha) begin
            value_nxt = sum[31:0];
            if (sum[35:32] != 4'd0) begin
              ovf_nxt = 1'b1;
            end
          end else if (c_char == CH_DOT) begin
            if (parts_r == MAX_EARLIER || ovf_r || value_r > MAX_BYTE) begin
              outcome_nxt = OUT_INVALID;
            end else begin
              part_wr   = 1'b1;
              parts_nxt = parts_r + 2'd1;
              phase_nxt = PH_START;
              base_nxt  = BASE_DEC;
              value_nxt = '0;
              ovf_nxt   = 1'b0;
            end
          end else if (is_space) begin
            phase_nxt = PH_TRAIL;
          end else begin
            outcome_nxt = OUT_INVALID;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      base_r    <= BASE_DEC;
      value_r   <= '0;
      ovf_r     <= 1'b0;
      parts_r   <= '0;
      outcome_r <= OUT_PENDING;
    end else begin
      phase_r   <= phase_nxt;
      base_r    <= base_nxt;
      value_r   <= value_nxt;
      ovf_r     <= ovf_nxt;
      parts_r   <= parts_nxt;
      outcome_r <= outcome_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (part_wr) begin
      earlier_r[parts_r] <= value_r[7:0];
    end
  end

  // final assembly of the address from the earlier parts
  always_comb begin
    ok   = (outcome_r == OUT_PENDING) && !ovf_r;
    addr = value_r;
    case (parts_r)
      2'd1: begin
        if (value_r > MAX_24) begin
          ok = 1'b0;
        end
        addr = value_r | {earlier_r[0], 24'b0};
      end
      2'd2: begin
        if (value_r > MAX_SHORT) begin
          ok = 1'b0;
        end
        addr = value_r | {earlier_r[0], earlier_r[1], 16'b0};
      end
      2'd3: begin
        if (value_r > MAX_BYTE) begin
          ok = 1'b0;
        end
        addr = value_r | {earlier_r[0], earlier_r[1], earlier_r[2], 8'b0};
      end
      default: begin
        addr = value_r;
      end
    endcase
    result.ok    = ok;
    result.value = ok ? addr : 32'b0;
  end

`ifndef NO_ASSERTIONS
  a_nul_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && c_char == CH_NUL) |=>
      (phase_r == PH_START && parts_r == 2'd0 && outcome_r == OUT_PENDING && !ovf_r))
    else $error("parser did not restart after end of string");

  a_zero_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ZERO) |-> (base_r == BASE_OCT && value_r == 32'd0))
    else $error("leading zero state with nonzero part or wrong base");

  a_ovf_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (phase_r == PH_DIGITS || phase_r == PH_TRAIL))
    else $error("part overflow outside digit phase");

  a_start_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_START) |-> (value_r == 32'd0 && !ovf_r && base_r == BASE_DEC))
    else $error("new part does not start clean");
`endif

endmodule

### sv/ipv4p_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4p_out_reg
// Result register: holds one address item until the receiver takes it.
// ----------------------------------------------------------------------------
module ipv4p_out_reg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  ipv4p_pkg::ipv4p_result_t result,
  input  logic                     out_stall,
  output logic                     out_free,
  output logic                     out_valid,
  output logic                     out_address_ok,
  output logic [31:0]              out_address_value
);
  import ipv4p_pkg::*;

  logic          out_valid_r;
  logic          out_valid_nxt;
  ipv4p_result_t res_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_address_ok    = res_r.ok;
  assign out_address_value = res_r.value;

endmodule

### sv/dotted_ipv4_address_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dotted_ipv4_address_parser_unit
// Character-stream parser for dotted IPv4 address in decimal, octal or hex.
// ----------------------------------------------------------------------------
// Takes one character item per cycle, sustained, with no gaps between
// strings. A string ends with a NUL character, which yields one result item:
// address_ok and the host-order address (zero when invalid). The input
// register takes the NUL, and the parse step then loads the result register
// from it once the result register is free. The only thing that holds off
// input is a NUL sitting in the input register while the result register is
// full and stalled; all other characters keep flowing.
module dotted_ipv4_address_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_address_ok,
  output logic [31:0] out_address_value
);
  import ipv4p_pkg::*;

  logic          c_valid;
  logic [7:0]    c_char;
  logic          out_free;
  logic          advance;
  logic          step_en;
  logic          res_load;
  ipv4p_result_t result;

  assign advance  = !c_valid || (c_char != CH_NUL) || out_free;
  assign in_stall = !advance;
  assign step_en  = c_valid && advance;
  assign res_load = step_en && (c_char == CH_NUL);

  ipv4p_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (advance),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .c_valid      (c_valid),
    .c_char       (c_char)
  );

  ipv4p_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .c_char  (c_char),
    .result  (result)
  );

  ipv4p_out_reg u_out_reg (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (res_load),
    .result            (result),
    .out_stall         (out_stall),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_address_ok    (out_address_ok),
    .out_address_value (out_address_value)
  );

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && c_valid && c_char == CH_NUL))
    else $error("input held off without a blocked end-of-string item");

  a_nul_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> out_valid)
    else $error("end of string did not produce a result item");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_address_ok) |-> (out_address_value == 32'd0))
    else $error("invalid result carries a nonzero address");
`endif

endmodule
